// ===== rtl/bex_pkg.sv =====
// ----------------------------------------------------------------------------
// Boundary extrapolation step: shared types and constants
// Item and result beats, configuration indexes, direction and fetch slot codes.
// ----------------------------------------------------------------------------
package bex_pkg;

	localparam int MAX_SIDE = 64;
	localparam int SIDE_W   = $clog2(MAX_SIDE);
	localparam int CELLS    = MAX_SIDE * MAX_SIDE;
	localparam int ADDR_W   = $clog2(CELLS);
	localparam int VTX_W    = 96;
	localparam int CFG_W    = 24;

	// configuration register indexes
	typedef logic [1:0] cfg_index_t;
	localparam cfg_index_t CFG_GROW_DIRECTION = 2'd0;
	localparam cfg_index_t CFG_STEP_LENGTH    = 2'd1;
	localparam cfg_index_t CFG_ROWS_IN_USE    = 2'd2;
	localparam cfg_index_t CFG_COLS_IN_USE    = 2'd3;

	// grow directions
	typedef logic [2:0] dir_t;
	localparam dir_t DIR_UP    = 3'd0;
	localparam dir_t DIR_DOWN  = 3'd1;
	localparam dir_t DIR_LEFT  = 3'd2;
	localparam dir_t DIR_RIGHT = 3'd3;
	localparam dir_t DIR_ALL   = 3'd4;

	// item actions
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	// fetch slots, in read order
	typedef logic [2:0] slot_t;
	localparam slot_t SLOT_POS = 3'd0;
	localparam slot_t SLOT_R1  = 3'd1;
	localparam slot_t SLOT_R0  = 3'd2;
	localparam slot_t SLOT_C1  = 3'd3;
	localparam slot_t SLOT_C0  = 3'd4;
	localparam slot_t SLOT_A   = 3'd5;
	localparam slot_t SLOT_B   = 3'd6;
	localparam int    SLOTS    = 7;

	// index 0 x, 1 y, 2 z
	typedef logic [2:0][31:0] vertex_t;

	typedef struct packed {
		logic               action;
		logic [5:0]         row;
		logic [5:0]         col;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] new_x;
		logic signed [31:0] new_y;
		logic signed [31:0] new_z;
		logic               on_boundary;
	} out_item_t;

	// everything the arithmetic pipeline needs for one query
	typedef struct packed {
		vertex_t pos;
		vertex_t a;
		vertex_t b;
		vertex_t r1;
		vertex_t r0;
		vertex_t c1;
		vertex_t c0;
		logic    bnd;
		logic    edge_mode;
	} fetch_t;

endpackage

// ===== rtl/bex_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One address per cycle, write or read, read data registered (read-first).
// ----------------------------------------------------------------------------
module bex_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write on enable, register the read word every cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// ===== rtl/bex_math.sv =====
// ----------------------------------------------------------------------------
// Boundary extrapolation arithmetic pipeline
// Differences, power-of-two fit, cross product, length by bit-serial square
// root stages, rounded division stages and saturating add. One beat a cycle.
// ----------------------------------------------------------------------------
module bex_math (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  bex_pkg::fetch_t     fetch,
	input  logic [23:0]         step_length,
	output logic                out_valid,
	output bex_pkg::out_item_t  out_item
);
	import bex_pkg::*;

	localparam int SQ_N  = 31;
	localparam int DIV_N = 25;
	localparam int FIT_MSB = 29;

	typedef struct packed {
		vertex_t          pos;
		logic             moved;
		logic [2:0]       neg;
		logic [2:0][53:0] prod;
	} tail_t;

	typedef struct packed {
		tail_t       t;
		logic [61:0] n;
		logic [61:0] res;
	} sq_t;

	typedef struct packed {
		vertex_t          pos;
		logic             moved;
		logic [2:0]       neg;
		logic [30:0]      len;
		logic [2:0][54:0] rem;
		logic [2:0][24:0] quo;
	} dv_t;

	function automatic logic [5:0] msb_pos(logic [63:0] v);
		logic [5:0] p;
		p = '0;
		for (int i = 0; i < 64; i++) begin
			if (v[i]) p = 6'(i);
		end
		return p;
	endfunction

	// {left, amount} that brings the leading one to bit FIT_MSB
	function automatic logic [6:0] fit_shift(logic [61:0] orv);
		logic [5:0] p;
		p = msb_pos(64'(orv));
		if (p < 6'(FIT_MSB)) return {1'b1, 6'(FIT_MSB) - p};
		return {1'b0, p - 6'(FIT_MSB)};
	endfunction

	function automatic logic [29:0] fit_mag(logic [61:0] m, logic [6:0] sh);
		if (sh[6]) return 30'(m << sh[5:0]);
		return 30'(m >> sh[5:0]);
	endfunction

	function automatic sq_t sqrt_step(sq_t s, logic [61:0] b);
		sq_t o;
		logic [61:0] t;
		o = s;
		t = s.res + b;
		if (s.n >= t) begin
			o.n   = s.n - t;
			o.res = (s.res >> 1) + b;
		end else begin
			o.res = s.res >> 1;
		end
		return o;
	endfunction

	function automatic dv_t div_step(dv_t d, int sh);
		dv_t o;
		logic [54:0] dsr;
		o = d;
		dsr = 55'(d.len) << sh;
		for (int j = 0; j < 3; j++) begin
			if (d.rem[j] >= dsr) begin
				o.rem[j]     = d.rem[j] - dsr;
				o.quo[j][sh] = 1'b1;
			end
		end
		return o;
	endfunction

	logic [11:1] vld_s;

	// stage 1: differences
	vertex_t            pos_s1;
	logic               bnd_s1, edge_s1;
	logic signed [32:0] e_s1 [3];
	logic signed [32:0] dr_s1 [3];
	logic signed [32:0] dc_s1 [3];
	// stage 2: magnitudes
	vertex_t            pos_s2;
	logic               bnd_s2, edge_s2, enz_s2;
	logic signed [32:0] e_s2 [3];
	logic [32:0]        mr_s2 [3];
	logic [32:0]        mc_s2 [3];
	logic [2:0]         nr_s2, nc_s2;
	logic [32:0]        or_r_s2, or_c_s2;
	// stage 3: fit shifts
	vertex_t            pos_s3;
	logic               bnd_s3, edge_s3, enz_s3;
	logic signed [32:0] e_s3 [3];
	logic [32:0]        mr_s3 [3];
	logic [32:0]        mc_s3 [3];
	logic [2:0]         nr_s3, nc_s3;
	logic [6:0]         shr_s3, shc_s3;
	// stage 4: fitted operands
	vertex_t            pos_s4;
	logic               bnd_s4, edge_s4, enz_s4;
	logic signed [32:0] e_s4 [3];
	logic signed [30:0] dr_s4 [3];
	logic signed [30:0] dc_s4 [3];
	// stage 5: partial products
	vertex_t            pos_s5;
	logic               bnd_s5, edge_s5, enz_s5;
	logic signed [32:0] e_s5 [3];
	logic signed [61:0] pp_s5 [6];
	// stage 6: direction
	vertex_t            pos_s6;
	logic               moved_s6;
	logic signed [62:0] vel_s6 [3];
	// stage 7: magnitudes
	vertex_t            pos_s7;
	logic               moved_s7;
	logic [2:0]         neg_s7;
	logic [61:0]        mv_s7 [3];
	logic [61:0]        or_s7;
	// stage 8: fit shift
	vertex_t            pos_s8;
	logic               moved_s8;
	logic [2:0]         neg_s8;
	logic [61:0]        mv_s8 [3];
	logic [6:0]         sh_s8;
	// stage 9: fitted direction
	vertex_t            pos_s9;
	logic               moved_s9;
	logic [2:0]         neg_s9;
	logic [29:0]        m_s9 [3];
	// stage 10: squares and step products
	logic [59:0]        sqr_s10 [3];
	tail_t              t_s10;
	// stage 11: sum of squares
	logic [61:0]        sum_s11;
	tail_t              t_s11;

	sq_t  sq_s  [SQ_N+1];
	logic sq_v_s [SQ_N+1];
	dv_t  dv_s  [DIV_N+1];
	logic dv_v_s [DIV_N+1];

	out_item_t res_sout;
	logic      done_sout;

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s     <= '0;
			done_sout <= 1'b0;
			for (int k = 0; k <= SQ_N; k++) sq_v_s[k] <= 1'b0;
			for (int k = 0; k <= DIV_N; k++) dv_v_s[k] <= 1'b0;
		end else begin
			vld_s <= {vld_s[10:1], in_valid};
			sq_v_s[0] <= vld_s[11];
			for (int k = 0; k < SQ_N; k++) sq_v_s[k+1] <= sq_v_s[k];
			dv_v_s[0] <= sq_v_s[SQ_N];
			for (int k = 0; k < DIV_N; k++) dv_v_s[k+1] <= dv_v_s[k];
			done_sout <= dv_v_s[DIV_N];
		end
	end

	// stages 1 to 4: differences and fit of the neighbour vectors
	always_ff @(posedge clk) begin
		pos_s1  <= fetch.pos;
		bnd_s1  <= fetch.bnd;
		edge_s1 <= fetch.edge_mode;
		for (int i = 0; i < 3; i++) begin
			e_s1[i]  <= $signed({fetch.b[i][31], fetch.b[i]})
				- $signed({fetch.a[i][31], fetch.a[i]});
			dr_s1[i] <= $signed({fetch.r1[i][31], fetch.r1[i]})
				- $signed({fetch.r0[i][31], fetch.r0[i]});
			dc_s1[i] <= $signed({fetch.c1[i][31], fetch.c1[i]})
				- $signed({fetch.c0[i][31], fetch.c0[i]});
		end

		pos_s2  <= pos_s1;
		bnd_s2  <= bnd_s1;
		edge_s2 <= edge_s1;
		enz_s2  <= (e_s1[0] != '0) || (e_s1[1] != '0) || (e_s1[2] != '0);
		or_r_s2 <= (dr_s1[0][32] ? 33'(-dr_s1[0]) : 33'(dr_s1[0]))
			| (dr_s1[1][32] ? 33'(-dr_s1[1]) : 33'(dr_s1[1]))
			| (dr_s1[2][32] ? 33'(-dr_s1[2]) : 33'(dr_s1[2]));
		or_c_s2 <= (dc_s1[0][32] ? 33'(-dc_s1[0]) : 33'(dc_s1[0]))
			| (dc_s1[1][32] ? 33'(-dc_s1[1]) : 33'(dc_s1[1]))
			| (dc_s1[2][32] ? 33'(-dc_s1[2]) : 33'(dc_s1[2]));
		for (int i = 0; i < 3; i++) begin
			e_s2[i]  <= e_s1[i];
			nr_s2[i] <= dr_s1[i][32];
			nc_s2[i] <= dc_s1[i][32];
			mr_s2[i] <= dr_s1[i][32] ? 33'(-dr_s1[i]) : 33'(dr_s1[i]);
			mc_s2[i] <= dc_s1[i][32] ? 33'(-dc_s1[i]) : 33'(dc_s1[i]);
		end

		pos_s3  <= pos_s2;
		bnd_s3  <= bnd_s2;
		edge_s3 <= edge_s2;
		enz_s3  <= enz_s2;
		nr_s3   <= nr_s2;
		nc_s3   <= nc_s2;
		shr_s3  <= fit_shift(62'(or_r_s2));
		shc_s3  <= fit_shift(62'(or_c_s2));
		for (int i = 0; i < 3; i++) begin
			e_s3[i]  <= e_s2[i];
			mr_s3[i] <= mr_s2[i];
			mc_s3[i] <= mc_s2[i];
		end

		pos_s4  <= pos_s3;
		bnd_s4  <= bnd_s3;
		edge_s4 <= edge_s3;
		enz_s4  <= enz_s3;
		for (int i = 0; i < 3; i++) begin
			e_s4[i]  <= e_s3[i];
			dr_s4[i] <= nr_s3[i] ? -$signed({1'b0, fit_mag(62'(mr_s3[i]), shr_s3)})
				: $signed({1'b0, fit_mag(62'(mr_s3[i]), shr_s3)});
			dc_s4[i] <= nc_s3[i] ? -$signed({1'b0, fit_mag(62'(mc_s3[i]), shc_s3)})
				: $signed({1'b0, fit_mag(62'(mc_s3[i]), shc_s3)});
		end
	end

	// stages 5 and 6: cross product, pick the move direction
	always_ff @(posedge clk) begin
		pos_s5  <= pos_s4;
		bnd_s5  <= bnd_s4;
		edge_s5 <= edge_s4;
		enz_s5  <= enz_s4;
		for (int i = 0; i < 3; i++) e_s5[i] <= e_s4[i];
		pp_s5[0] <= dr_s4[1] * dc_s4[2];
		pp_s5[1] <= dr_s4[2] * dc_s4[1];
		pp_s5[2] <= dr_s4[2] * dc_s4[0];
		pp_s5[3] <= dr_s4[0] * dc_s4[2];
		pp_s5[4] <= dr_s4[0] * dc_s4[1];
		pp_s5[5] <= dr_s4[1] * dc_s4[0];

		pos_s6 <= pos_s5;
		if (edge_s5 && enz_s5) begin
			moved_s6 <= bnd_s5;
			for (int i = 0; i < 3; i++) vel_s6[i] <= 63'(e_s5[i]);
		end else begin
			moved_s6 <= bnd_s5 && ((pp_s5[0] != pp_s5[1]) || (pp_s5[2] != pp_s5[3])
				|| (pp_s5[4] != pp_s5[5]));
			vel_s6[0] <= 63'(pp_s5[0]) - 63'(pp_s5[1]);
			vel_s6[1] <= 63'(pp_s5[2]) - 63'(pp_s5[3]);
			vel_s6[2] <= 63'(pp_s5[4]) - 63'(pp_s5[5]);
		end
	end

	// stages 7 to 11: fit the direction, squares and step products
	always_ff @(posedge clk) begin
		pos_s7   <= pos_s6;
		moved_s7 <= moved_s6;
		or_s7    <= (vel_s6[0][62] ? 62'(-vel_s6[0]) : 62'(vel_s6[0]))
			| (vel_s6[1][62] ? 62'(-vel_s6[1]) : 62'(vel_s6[1]))
			| (vel_s6[2][62] ? 62'(-vel_s6[2]) : 62'(vel_s6[2]));
		for (int i = 0; i < 3; i++) begin
			neg_s7[i] <= vel_s6[i][62];
			mv_s7[i]  <= vel_s6[i][62] ? 62'(-vel_s6[i]) : 62'(vel_s6[i]);
		end

		pos_s8   <= pos_s7;
		moved_s8 <= moved_s7;
		neg_s8   <= neg_s7;
		sh_s8    <= fit_shift(or_s7);
		for (int i = 0; i < 3; i++) mv_s8[i] <= mv_s7[i];

		pos_s9   <= pos_s8;
		moved_s9 <= moved_s8;
		neg_s9   <= neg_s8;
		for (int i = 0; i < 3; i++) m_s9[i] <= fit_mag(mv_s8[i], sh_s8);

		t_s10.pos   <= pos_s9;
		t_s10.moved <= moved_s9;
		t_s10.neg   <= neg_s9;
		for (int i = 0; i < 3; i++) begin
			sqr_s10[i]      <= 60'(m_s9[i]) * 60'(m_s9[i]);
			t_s10.prod[i]   <= 54'(m_s9[i]) * 54'(step_length);
		end

		t_s11   <= t_s10;
		sum_s11 <= 62'(sqr_s10[0]) + 62'(sqr_s10[1]) + 62'(sqr_s10[2]);
	end

	// square root stages, one result bit each
	always_ff @(posedge clk) begin
		sq_s[0].t   <= t_s11;
		sq_s[0].n   <= sum_s11;
		sq_s[0].res <= '0;
		for (int k = 0; k < SQ_N; k++) begin
			sq_s[k+1] <= sqrt_step(sq_s[k], 62'(1) << (2 * (SQ_N - 1 - k)));
		end
	end

	// rounded division stages, one quotient bit of each lane each
	always_ff @(posedge clk) begin
		dv_s[0].pos   <= sq_s[SQ_N].t.pos;
		dv_s[0].moved <= sq_s[SQ_N].t.moved;
		dv_s[0].neg   <= sq_s[SQ_N].t.neg;
		dv_s[0].len   <= sq_s[SQ_N].res[30:0];
		dv_s[0].quo   <= '0;
		for (int j = 0; j < 3; j++) begin
			dv_s[0].rem[j] <= 55'(sq_s[SQ_N].t.prod[j]) + 55'(sq_s[SQ_N].res[30:1]);
		end
		for (int k = 0; k < DIV_N; k++) begin
			dv_s[k+1] <= div_step(dv_s[k], DIV_N - 1 - k);
		end
	end

	// apply the delta and saturate
	logic signed [33:0] q34 [3];
	logic signed [33:0] sum34 [3];
	logic [2:0][31:0]   grown;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			q34[i]   = $signed({9'b0, dv_s[DIV_N].quo[i]});
			sum34[i] = $signed({{2{dv_s[DIV_N].pos[i][31]}}, dv_s[DIV_N].pos[i]})
				+ (dv_s[DIV_N].neg[i] ? -q34[i] : q34[i]);
			if (!dv_s[DIV_N].moved) begin
				grown[i] = dv_s[DIV_N].pos[i];
			end else if (sum34[i] > 34'sd2147483647) begin
				grown[i] = 32'h7FFF_FFFF;
			end else if (sum34[i] < -34'sd2147483648) begin
				grown[i] = 32'h8000_0000;
			end else begin
				grown[i] = sum34[i][31:0];
			end
		end
	end

	// hold the result beat for one cycle
	always_ff @(posedge clk) begin
		res_sout.new_x       <= grown[0];
		res_sout.new_y       <= grown[1];
		res_sout.new_z       <= grown[2];
		res_sout.on_boundary <= dv_s[DIV_N].moved;
	end

	assign out_valid = done_sout;
	assign out_item  = res_sout;

endmodule

// ===== rtl/boundary_extrapolation_step_unit.sv =====
// ----------------------------------------------------------------------------
// Boundary extrapolation step unit
// Vertex grid store with a fetch sequencer in front of the arithmetic pipeline.
// ----------------------------------------------------------------------------
// A write beat is taken without raising busy. A query beat holds busy while its
// vertices are read from the single-port vertex store, one per cycle: one read
// off the selected boundary, five in all-boundaries mode, seven on a single
// boundary; the next beat is taken only once those reads are issued. done is
// raised once the query has passed the fetch, 11 arithmetic stages, 32
// square-root and 26 division registers and the result register. The result
// sits on result for the one cycle done is high; the receiver cannot stall it.
// The user must write configuration only while no query is in flight; the block
// itself does not enforce it. The store is not cleared: query only vertices that have been written.
module boundary_extrapolation_step_unit (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  bex_pkg::in_item_t      item,
	output logic                   done,
	output bex_pkg::out_item_t     result,
	input  logic                   cfg_we,
	input  bex_pkg::cfg_index_t    cfg_index,
	input  logic [bex_pkg::CFG_W-1:0] cfg_data
);
	import bex_pkg::*;

	dir_t        grow_dir_q;
	logic [23:0] step_q;
	logic [6:0]  rows_q, cols_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grow_dir_q <= DIR_ALL;
			step_q     <= 24'd65536;
			rows_q     <= 7'(MAX_SIDE);
			cols_q     <= 7'(MAX_SIDE);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_GROW_DIRECTION: grow_dir_q <= cfg_data[2:0];
				CFG_STEP_LENGTH:    step_q     <= cfg_data;
				CFG_ROWS_IN_USE:    rows_q     <= cfg_data[6:0];
				CFG_COLS_IN_USE:    cols_q     <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// clamp grid size and direction
	logic [6:0] nr, nc;
	dir_t       dir_c;
	logic       in_grid, bnd_c;

	always_comb begin
		nr = (rows_q < 7'd2) ? 7'd2 : (rows_q > 7'(MAX_SIDE)) ? 7'(MAX_SIDE) : rows_q;
		nc = (cols_q < 7'd2) ? 7'd2 : (cols_q > 7'(MAX_SIDE)) ? 7'(MAX_SIDE) : cols_q;
		dir_c = (grow_dir_q > DIR_ALL) ? DIR_ALL : grow_dir_q;
		in_grid = ({1'b0, item.row} < nr) && ({1'b0, item.col} < nc);
		case (dir_c)
			DIR_UP:    bnd_c = item.row == '0;
			DIR_DOWN:  bnd_c = item.row == 6'(nr - 7'd1);
			DIR_LEFT:  bnd_c = item.col == '0;
			DIR_RIGHT: bnd_c = item.col == 6'(nc - 7'd1);
			default:   bnd_c = (item.row == '0) || (item.row == 6'(nr - 7'd1))
				|| (item.col == '0) || (item.col == 6'(nc - 7'd1));
		endcase
		bnd_c = bnd_c && in_grid;
	end

	logic accept, acc_wr, acc_q;
	assign accept = start && !busy;
	assign acc_wr = accept && (item.action == ACT_WRITE);
	assign acc_q  = accept && (item.action == ACT_QUERY);

	// fetch sequencer
	logic              active_q;
	slot_t             slot_q, last_q;
	logic [SIDE_W-1:0] row_q, col_q, nr1_q, nc1_q;
	dir_t              dir_q;
	logic              bnd_q, edge_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			slot_q   <= SLOT_POS;
		end else if (acc_q) begin
			active_q <= 1'b1;
			slot_q   <= SLOT_POS;
		end else if (active_q) begin
			slot_q <= slot_q + 3'd1;
			if (slot_q == last_q) active_q <= 1'b0;
		end
	end

	// latch the query geometry
	always_ff @(posedge clk) begin
		if (acc_q) begin
			row_q  <= item.row;
			col_q  <= item.col;
			nr1_q  <= 6'(nr - 7'd1);
			nc1_q  <= 6'(nc - 7'd1);
			dir_q  <= dir_c;
			bnd_q  <= bnd_c;
			edge_q <= dir_c != DIR_ALL;
			last_q <= !bnd_c ? SLOT_POS : (dir_c != DIR_ALL) ? SLOT_B : SLOT_C0;
		end
	end

	// address of the slot being read
	logic [ADDR_W-1:0] rd_addr;

	always_comb begin
		unique case (slot_q)
			SLOT_POS: rd_addr = {row_q, col_q};
			SLOT_R1:  rd_addr = {(row_q == nr1_q) ? row_q : row_q + 6'd1, col_q};
			SLOT_R0:  rd_addr = {(row_q == '0) ? row_q : row_q - 6'd1, col_q};
			SLOT_C1:  rd_addr = {row_q, (col_q == nc1_q) ? col_q : col_q + 6'd1};
			SLOT_C0:  rd_addr = {row_q, (col_q == '0) ? col_q : col_q - 6'd1};
			SLOT_A: begin
				unique case (dir_q)
					DIR_UP:   rd_addr = {6'd1, col_q};
					DIR_DOWN: rd_addr = {nr1_q - 6'd1, col_q};
					DIR_LEFT: rd_addr = {row_q, 6'd1};
					default:  rd_addr = {row_q, nc1_q - 6'd1};
				endcase
			end
			default: begin
				unique case (dir_q)
					DIR_UP:   rd_addr = {6'd0, col_q};
					DIR_DOWN: rd_addr = {nr1_q, col_q};
					DIR_LEFT: rd_addr = {row_q, 6'd0};
					default:  rd_addr = {row_q, nc1_q};
				endcase
			end
		endcase
	end

	logic [ADDR_W-1:0] ram_addr;
	logic [VTX_W-1:0]  ram_rdata;

	assign ram_addr = acc_wr ? {item.row, item.col} : rd_addr;

	bex_ram #(
		.WIDTH (VTX_W),
		.DEPTH (CELLS)
	) u_store (
		.clk   (clk),
		.we    (acc_wr),
		.addr  (ram_addr),
		.wdata ({item.pos_z, item.pos_y, item.pos_x}),
		.rdata (ram_rdata)
	);

	// track the read in flight
	logic  rd_valid_q, rd_last_q, launch_q;
	slot_t rd_slot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_q <= 1'b0;
			rd_last_q  <= 1'b0;
			launch_q   <= 1'b0;
		end else begin
			rd_valid_q <= active_q;
			rd_last_q  <= active_q && (slot_q == last_q);
			launch_q   <= rd_valid_q && rd_last_q;
		end
	end

	// capture fetched vertices
	vertex_t vtx_q [SLOTS];
	logic    bnd_f_q, edge_f_q;

	always_ff @(posedge clk) begin
		rd_slot_q <= slot_q;
		if (rd_valid_q) begin
			vtx_q[rd_slot_q] <= ram_rdata;
			if (rd_last_q) begin
				bnd_f_q  <= bnd_q;
				edge_f_q <= edge_q;
			end
		end
	end

	fetch_t fetch;

	always_comb begin
		fetch.pos       = vtx_q[SLOT_POS];
		fetch.r1        = vtx_q[SLOT_R1];
		fetch.r0        = vtx_q[SLOT_R0];
		fetch.c1        = vtx_q[SLOT_C1];
		fetch.c0        = vtx_q[SLOT_C0];
		fetch.a         = vtx_q[SLOT_A];
		fetch.b         = vtx_q[SLOT_B];
		fetch.bnd       = bnd_f_q;
		fetch.edge_mode = edge_f_q;
	end

	bex_math u_math (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (launch_q),
		.fetch       (fetch),
		.step_length (step_q),
		.out_valid   (done),
		.out_item    (result)
	);

	assign busy = active_q;

endmodule
